/* design/prtt_pkg.sv */
`default_nettype none
package prtt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int AGE_W       = 24;
  localparam int EPOCH_W     = 16;

  localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};
  localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(1000);

  typedef enum logic [1:0] {
    MODE_TRACK    = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE        = 2'd0,
    STAT_DUPLICATE   = 2'd1,
    STAT_FULL        = 2'd2,
    STAT_NOT_PENDING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_HEAD_RD,
    S_HEAD_CMP,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    mode_t              mode;
    logic [ID_BITS-1:0] request_id;
    logic [TIME_W-1:0]  accepted_time;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         pending_count;
    logic               watch_valid;
    logic [ID_BITS-1:0] watch_id;
    logic               expiry_fired;
    logic [EPOCH_W-1:0] epoch;
  } rsp_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [TIME_W-1:0]  acc_time;
  } entry_t;

endpackage
`default_nettype wire

/* design/prtt_ram.sv */
`default_nettype none
module prtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/pending_request_timeout_tracker_unit.sv */
// sequence: tick and clear go straight to the response; track and complete scan the
//   pending entries (read, then compare), then shift entries, then reload the watch if needed
// flow: one item at a time, a new request is taken only in the idle state; the
//   single entry table RAM is walked one entry at a time (read, then compare/write)
// reset: synchronous, empties the table, clears the watch and epoch, sets timeout to 1000
`default_nettype none
module pending_request_timeout_tracker_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire prtt_pkg::req_item_t        req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output prtt_pkg::rsp_item_t             rsp,
  input  wire logic                       cfg_we,
  input  wire logic [prtt_pkg::AGE_W-1:0] cfg_data
);
  import prtt_pkg::*;

  fsm_t               state, state_next;
  req_item_t          item, item_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               watching, watching_next;
  logic [ID_BITS-1:0] watched_id, watched_id_next;
  logic [AGE_W-1:0]   watch_age, watch_age_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic               fired_epoch, fired_epoch_next;
  logic [AGE_W-1:0]   timeout, timeout_next;
  status_t            status, status_next;
  logic               fire, fire_next;
  logic               rsp_valid_next;
  rsp_item_t          rsp_next;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  logic [AGE_W-1:0]   age_inc, limit;
  entry_t             new_entry;

  prtt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign age_inc   = (watch_age == AGE_MAX) ? watch_age : watch_age + 1'b1;
  assign limit     = (timeout == '0) ? AGE_W'(1) : timeout;
  assign new_entry = '{id: item.request_id, acc_time: item.accepted_time};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      watching    <= 1'b0;
      watched_id  <= '0;
      watch_age   <= '0;
      epoch       <= '0;
      fired_epoch <= 1'b0;
      timeout     <= TIMEOUT_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      watching    <= watching_next;
      watched_id  <= watched_id_next;
      watch_age   <= watch_age_next;
      epoch       <= epoch_next;
      fired_epoch <= fired_epoch_next;
      timeout     <= timeout_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item   <= item_next;
    idx    <= idx_next;
    status <= status_next;
    fire   <= fire_next;
    rsp    <= rsp_next;
  end

  // sequencer: search, shift and watch reload over the table RAM
  always_comb begin
    state_next       = state;
    item_next        = item;
    count_next       = count;
    idx_next         = idx;
    watching_next    = watching;
    watched_id_next  = watched_id;
    watch_age_next   = watch_age;
    epoch_next       = epoch;
    fired_epoch_next = fired_epoch;
    timeout_next     = timeout;
    status_next      = status;
    fire_next        = fire;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    req_ready        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = new_entry;
    ram_raddr        = '0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          item_next   = req;
          status_next = STAT_DONE;
          fire_next   = 1'b0;
          idx_next    = '0;
          case (req.mode)
            MODE_TRACK, MODE_COMPLETE: begin
              state_next = S_SCAN_RD;
            end
            MODE_TICK: begin
              if (watching) begin
                watch_age_next = age_inc;
                if (!fired_epoch && age_inc >= limit) begin
                  fired_epoch_next = 1'b1;
                  fire_next        = 1'b1;
                end
              end
              state_next = S_FINISH;
            end
            default: begin
              count_next       = '0;
              epoch_next       = epoch + 1'b1;
              fired_epoch_next = 1'b0;
              watch_age_next   = '0;
              watching_next    = 1'b0;
              watched_id_next  = '0;
              state_next       = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx == count) begin
          if (item.mode == MODE_TRACK) begin
            if (count == CNT_W'(TABLE_DEPTH)) begin
              status_next = STAT_FULL;
              state_next  = S_FINISH;
            end else begin
              state_next = S_INS_RD;
            end
          end else begin
            status_next = STAT_NOT_PENDING;
            state_next  = S_FINISH;
          end
        end else begin
          ram_raddr  = idx[IDX_W-1:0];
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (ram_rdata.id == item.request_id) begin
          if (item.mode == MODE_TRACK) begin
            status_next = STAT_DUPLICATE;
            state_next  = S_FINISH;
          end else begin
            state_next = S_DEL_RD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      // insertion walks down from the tail, moving later entries up one slot
      S_INS_RD: begin
        if (idx == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          count_next = count + 1'b1;
          if (!watching) begin
            epoch_next       = epoch + 1'b1;
            fired_epoch_next = 1'b0;
            watch_age_next   = '0;
            state_next       = S_HEAD_RD;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          ram_raddr  = IDX_W'(idx - 1'b1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        if (ram_rdata.acc_time > item.accepted_time) begin
          ram_wdata  = ram_rdata;
          idx_next   = idx - 1'b1;
          state_next = S_INS_RD;
        end else begin
          count_next = count + 1'b1;
          if (!watching) begin
            epoch_next       = epoch + 1'b1;
            fired_epoch_next = 1'b0;
            watch_age_next   = '0;
            state_next       = S_HEAD_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      // removal moves later entries down one slot
      S_DEL_RD: begin
        if (CNT_W'(idx + 1'b1) < count) begin
          ram_raddr  = IDX_W'(idx + 1'b1);
          state_next = S_DEL_CMP;
        end else begin
          count_next = count - 1'b1;
          state_next = S_FINISH;
          if (watching && watched_id == item.request_id) begin
            epoch_next       = epoch + 1'b1;
            fired_epoch_next = 1'b0;
            watch_age_next   = '0;
            if (count != CNT_W'(1)) begin
              state_next = S_HEAD_RD;
            end else begin
              watching_next   = 1'b0;
              watched_id_next = '0;
            end
          end
        end
      end
      S_DEL_CMP: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[IDX_W-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx + 1'b1;
        state_next = S_DEL_RD;
      end
      // oldest entry sits in slot zero
      S_HEAD_RD: begin
        ram_raddr  = '0;
        state_next = S_HEAD_CMP;
      end
      S_HEAD_CMP: begin
        watched_id_next = ram_rdata.id;
        watching_next   = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.status        = status;
          rsp_next.pending_count = 6'(count);
          rsp_next.watch_valid   = watching;
          rsp_next.watch_id      = watching ? watched_id : '0;
          rsp_next.expiry_fired  = fire;
          rsp_next.epoch         = epoch;
          rsp_valid_next         = 1'b1;
          state_next             = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // timeout write opens a new epoch
    if (cfg_we) begin
      timeout_next     = cfg_data;
      epoch_next       = epoch_next + 1'b1;
      fired_epoch_next = 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("pending count above table depth");

  a_watch_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && watching) |-> count != '0)
    else $error("watch held with empty table");

  a_fire_has_watch: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.expiry_fired) |-> rsp.watch_valid)
    else $error("expiry reported without a watch");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_INS_RD || state == S_INS_CMP || state == S_DEL_CMP))
    else $error("table written outside insert or remove");

endmodule
`default_nettype wire

/* sim/pending_request_timeout_tracker_unit_checker.sv */
`timescale 1ns / 100ps
module pending_request_timeout_tracker_unit_checker
  import prtt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic                 req_ready,
  input  wire req_item_t            req,
  input  wire logic                 rsp_valid,
  input  wire logic                 rsp_ready,
  input  wire rsp_item_t            rsp,
  input  wire logic                 cfg_we,
  input  wire logic [AGE_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        pending_rsp,
  output int                        rsp_seen,
  output int                        expiry_seen
);

  // tracker mirror state
  logic [ID_BITS-1:0] tbl_id [TABLE_DEPTH];
  logic [TIME_W-1:0]  tbl_time [TABLE_DEPTH];
  int                 tbl_count;
  logic               watch_on;
  logic [ID_BITS-1:0] watch_key;
  logic [AGE_W-1:0]   age;
  logic [EPOCH_W-1:0] epoch_cnt;
  logic               fired_epoch;
  logic [AGE_W-1:0]   timeout;

  rsp_item_t expected_rsp_q[$];

  assign pending_rsp = expected_rsp_q.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic int lookup_id(input logic [ID_BITS-1:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void rewatch();
    epoch_cnt++;
    fired_epoch = 1'b0;
    age = '0;
    watch_on = tbl_count > 0;
    watch_key = watch_on ? tbl_id[0] : '0;
  endfunction

  function automatic rsp_item_t apply_item(input req_item_t it);
    rsp_item_t r;
    int slot;
    int pos;
    logic [AGE_W-1:0] limit;
    r = '0;
    r.status = STAT_DONE;
    case (it.mode)
      MODE_TRACK: begin
        if (lookup_id(it.request_id) >= 0) begin
          r.status = STAT_DUPLICATE;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_time[pos] <= it.accepted_time) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_time[i] = tbl_time[i-1];
          end
          tbl_id[pos] = it.request_id;
          tbl_time[pos] = it.accepted_time;
          tbl_count++;
          if (!watch_on) rewatch();
        end
      end
      MODE_COMPLETE: begin
        slot = lookup_id(it.request_id);
        if (slot < 0) begin
          r.status = STAT_NOT_PENDING;
        end else begin
          for (int i = slot; i + 1 < tbl_count; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_time[i] = tbl_time[i+1];
          end
          tbl_count--;
          if (watch_on && watch_key == it.request_id) rewatch();
        end
      end
      MODE_TICK: begin
        if (watch_on) begin
          limit = (timeout == '0) ? AGE_W'(1) : timeout;
          if (age != AGE_MAX) age++;
          if (!fired_epoch && age >= limit) begin
            fired_epoch = 1'b1;
            r.expiry_fired = 1'b1;
          end
        end
      end
      default: begin
        tbl_count = 0;
        rewatch();
      end
    endcase
    r.pending_count = 6'(tbl_count);
    r.watch_valid = watch_on;
    r.watch_id = watch_on ? watch_key : '0;
    r.epoch = epoch_cnt;
    return r;
  endfunction

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      tbl_count <= 0;
      watch_on <= 1'b0;
      watch_key <= '0;
      age <= '0;
      epoch_cnt <= '0;
      fired_epoch <= 1'b0;
      timeout <= TIMEOUT_RESET;
      fail_count <= 0;
      rsp_seen <= 0;
      expiry_seen <= 0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_we) begin
        timeout = cfg_data;
        epoch_cnt++;
        fired_epoch = 1'b0;
      end
      if (req_valid && req_ready) expected_rsp_q = {expected_rsp_q, apply_item(req)};
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (rsp.expiry_fired) expiry_seen++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(rsp), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.pending_count !== want.pending_count)
            report_mismatch("pending_count", rsp.pending_count, want.pending_count);
          if (rsp.watch_valid !== want.watch_valid)
            report_mismatch("watch_valid", rsp.watch_valid, want.watch_valid);
          if (rsp.watch_id !== want.watch_id)
            report_mismatch("watch_id", rsp.watch_id, want.watch_id);
          if (rsp.expiry_fired !== want.expiry_fired)
            report_mismatch("expiry_fired", rsp.expiry_fired, want.expiry_fired);
          if (rsp.epoch !== want.epoch)
            report_mismatch("epoch", rsp.epoch, want.epoch);
        end
      end
    end
  end

endmodule

/* sim/pending_request_timeout_tracker_unit_tb.sv */
`timescale 1ns / 100ps
module pending_request_timeout_tracker_unit_tb;
  import prtt_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 1500000;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_item_t         req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_item_t         rsp;
  logic              cfg_we;
  logic [AGE_W-1:0]  cfg_data;
  int                fail_count;
  int                pending_rsp;
  int                rsp_seen;
  int                expiry_seen;
  int                cycle_count;
  logic              sink_idle_on;
  logic              long_hold;
  logic              quiet_tail;
  logic [ID_BITS-1:0] id_pool [8];

  pending_request_timeout_tracker_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  pending_request_timeout_tracker_unit_checker u_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_rsp(pending_rsp),
    .rsp_seen(rsp_seen), .expiry_seen(expiry_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls: random bursts, one long hold-off
  initial begin
    int gap;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        rsp_ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if (sink_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        rsp_ready = 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(input mode_t m, input logic [ID_BITS-1:0] id,
                           input logic [TIME_W-1:0] t);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req.mode = m;
    req.request_id = id;
    req.accepted_time = t;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic write_timeout(input logic [AGE_W-1:0] v);
    while (pending_rsp != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_item(input int phase);
    int pick;
    logic [ID_BITS-1:0] id;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom) : id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: t = TIME_W'($urandom_range(0, 7));
      2: t = 32'hFFFF_FFF8 | TIME_W'($urandom_range(0, 7));
      default: t = TIME_W'($urandom_range(0, 1000));
    endcase
    // fill phase sends more fresh IDs to track, drain phase more completes
    if (pick < (phase == 0 ? 45 : 25)) send_item(MODE_TRACK, ID_BITS'($urandom), t);
    else if (pick < 55) send_item(MODE_TRACK, id, t);
    else if (pick < (phase == 0 ? 70 : 80)) send_item(MODE_COMPLETE, id, t);
    else if (pick < 98) send_item(MODE_TICK, id, t);
    else send_item(MODE_CLEAR, id, t);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycle_count = 0;
    sink_idle_on = 1'b0;
    long_hold = 1'b0;
    quiet_tail = 1'b0;
    for (int i = 0; i < 8; i++) id_pool[i] = ID_BITS'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: empty cases, extremes, equal times, duplicate, expiry, saturation
    send_item(MODE_TICK, 16'h0000, 32'h0);
    send_item(MODE_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(MODE_TRACK, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(MODE_TRACK, 16'h0000, 32'h0000_0000);
    send_item(MODE_TRACK, 16'h5555, 32'h0000_0000);
    send_item(MODE_TRACK, 16'hAAAA, 32'h0000_0000);
    send_item(MODE_TRACK, 16'h5555, 32'h1234_5678);
    send_item(MODE_COMPLETE, 16'hFFFF, 32'h0);
    send_item(MODE_COMPLETE, 16'hAAAA, 32'h0);
    write_timeout(24'd1);
    send_item(MODE_TICK, 16'h0, 32'h0);
    send_item(MODE_TICK, 16'h0, 32'h0);
    write_timeout(24'd0);
    send_item(MODE_TICK, 16'h0, 32'h0);
    send_item(MODE_COMPLETE, 16'h0000, 32'h0);
    send_item(MODE_TICK, 16'h0, 32'h0);
    send_item(MODE_CLEAR, 16'h0, 32'h0);
    send_item(MODE_TICK, 16'h0, 32'h0);
    for (int i = 0; i < 33; i++) send_item(MODE_TRACK, 16'(i * 3 + 7), 32'(33 - i));
    send_item(MODE_CLEAR, 16'h0, 32'h0);

    // random phases under several timeout settings
    sink_idle_on = 1'b1;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_timeout(24'd3);
        1: write_timeout(24'hFF_FFFF);
        2: write_timeout(24'd1);
        3: write_timeout(24'($urandom_range(2, 40)));
        4: write_timeout(24'd1000);
        5: write_timeout(24'd5);
        default: write_timeout(24'd2);
      endcase
      if (p == 2) long_hold = 1'b1;
      if (p == 6) quiet_tail = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS / 7; i++) random_item((i / 50) % 2);
    end

    while (pending_rsp != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("covered %0d responses, %0d expiries, table fill and drain, all modes",
             rsp_seen, expiry_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
